@@ rtl/ctms_pkg.sv @@
// Shared types and constants for the clip template mean/stdev accumulator.
package ctms_pkg;

  localparam int NUM_CLASSES  = 16;
  localparam int NUM_CHANNELS = 8;
  localparam int CLIP_LEN     = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int MIN_CLIPS    = 2;

  localparam int ELEMS       = CLIP_LEN * NUM_CHANNELS;
  localparam int STORE_DEPTH = NUM_CLASSES * ELEMS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 48;
  localparam int CNT_W       = 16;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int DIV_W       = 40;
  localparam int REM_W       = CNT_W + 1;
  localparam int RT_W        = 40;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_READ,
    OP_READ_NOCLS
  } ctms_op_t;

  typedef struct packed {
    ctms_op_t                 op;
    logic [CLS_W-1:0]         cls;
    logic [ADDR_W-1:0]        addr;
    logic                     elem_ok;
    logic [SAMPLE_BITS-1:0]   sample;
    logic                     clip_end;
  } ctms_entry_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } ctms_bk_stat_t;

endpackage

@@ rtl/ctms_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ctms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ctms_front.sv @@
// Front end: classifies incoming items and queues them for the engine.
module ctms_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_action,
  input  logic [4:0]                    in_label,
  input  logic [8:0]                    in_element_index,
  input  logic signed [15:0]            in_sample,
  input  logic                          in_clip_end,
  input  ctms_pkg::ctms_bk_stat_t       bk_stat,
  output ctms_pkg::ctms_entry_t         head,
  output logic                          q_empty
);

  ctms_pkg::ctms_entry_t       q_r [ctms_pkg::QDEPTH];
  logic [ctms_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [ctms_pkg::QPTR_W:0]   cnt_r;
  ctms_pkg::ctms_entry_t       ent;
  logic                        lbl_ok, el_ok, keep, xfer;

  always_comb begin
    lbl_ok = (in_label >= 5'd1) && (32'(in_label) <= ctms_pkg::NUM_CLASSES);
    el_ok  = 32'(in_element_index) < ctms_pkg::ELEMS;
    ent.cls = ctms_pkg::CLS_W'(in_label - 5'd1);
    ent.addr = ctms_pkg::ADDR_W'(ctms_pkg::ADDR_W'(ent.cls) * ctms_pkg::ADDR_W'(ctms_pkg::ELEMS))
             + ctms_pkg::ADDR_W'(in_element_index);
    ent.elem_ok  = el_ok;
    ent.sample   = ctms_pkg::SAMPLE_BITS'(in_sample);
    ent.clip_end = in_clip_end;
    if (!in_action) begin
      ent.op = ctms_pkg::OP_ACC;
    end else if (lbl_ok) begin
      ent.op = ctms_pkg::OP_READ;
    end else begin
      ent.op = ctms_pkg::OP_READ_NOCLS;
    end
    // bad accumulates are dropped here and never queued
    keep = in_action || (lbl_ok && el_ok);
  end

  assign full    = bk_stat.clearing || (cnt_r == (ctms_pkg::QPTR_W+1)'(ctms_pkg::QDEPTH));
  assign xfer    = push && !full;
  assign q_empty = (cnt_r == '0);
  assign head    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (xfer && keep) begin
        q_r[wp_r] <= ent;
        wp_r      <= wp_r + 1'b1;
      end
      if (bk_stat.pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (ctms_pkg::QPTR_W+1)'(xfer && keep) - (ctms_pkg::QPTR_W+1)'(bk_stat.pop);
    end
  end

endmodule

@@ rtl/ctms_back.sv @@
// Back end: store update, clearing pass, and mean/stdev engine.
module ctms_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctms_pkg::ctms_entry_t   head,
  input  logic                    q_empty,
  output ctms_pkg::ctms_bk_stat_t bk_stat,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [23:0]      out_mean_value,
  output logic [23:0]             out_stdev_value,
  output logic [15:0]             out_clip_count,
  output logic                    out_enough_clips
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ACC, S_MUL1, S_MUL2, S_LHS, S_SUB,
    S_DIVM, S_MFIN, S_SQRT, S_DIVS, S_SFIN, S_DONE
  } st_t;

  localparam int MW = ctms_pkg::SUM_W + ctms_pkg::SQ_W;
  localparam int IT_W = $clog2(ctms_pkg::DIV_W + 1);

  st_t                            st_r;
  logic [ctms_pkg::ADDR_W-1:0]    clr_r, addr_r;
  logic [ctms_pkg::CNT_W-1:0]     cnt_r [ctms_pkg::NUM_CLASSES];
  logic [ctms_pkg::CLS_W-1:0]     cls_r;
  logic [ctms_pkg::CNT_W-1:0]     n_r;
  logic signed [ctms_pkg::SUM_W-1:0] samp_r;
  logic [33:0]                    sq_r;
  logic                           ce_r;
  logic signed [ctms_pkg::SUM_W-1:0] sum_r;
  logic [ctms_pkg::SQ_W-1:0]      sqs_r;
  logic [63:0]                    rhs_r, plo_r, phi_r, lhs_r;
  logic                           neg_r, vz_r;
  logic [IT_W-1:0]                it_r;
  logic [ctms_pkg::DIV_W-1:0]     dq_r;
  logic [ctms_pkg::REM_W-1:0]     drem_r;
  logic [79:0]                    rad_r;
  logic [41:0]                    srem_r;
  logic [ctms_pkg::RT_W-1:0]      root_r;
  logic [23:0]                    mean_r;
  logic                           ov_r;

  logic                           we, do_pop;
  logic [ctms_pkg::ADDR_W-1:0]    waddr;
  logic [MW-1:0]                  wdata, rdata;
  logic [ctms_pkg::SUM_W-1:0]     rd_sum;
  logic [ctms_pkg::SQ_W-1:0]      rd_sq;
  logic [ctms_pkg::REM_W-1:0]     drem2, drem_nxt;
  logic [ctms_pkg::DIV_W-1:0]     dq_nxt;
  logic [41:0]                    srem2, trial;
  logic [ctms_pkg::CNT_W-1:0]     hcnt;
  logic signed [16:0]             hs;
  logic [16:0]                    habs;
  logic [40:0]                    mmag;
  logic [31:0]                    asum;

  assign rd_sum = rdata[MW-1 -: ctms_pkg::SUM_W];
  assign rd_sq  = rdata[ctms_pkg::SQ_W-1:0];
  assign hcnt   = cnt_r[head.cls];
  assign do_pop = (st_r == S_IDLE) && !q_empty;
  assign bk_stat.pop      = do_pop;
  assign bk_stat.clearing = (st_r == S_CLEAR);
  assign empty  = !ov_r;
  assign hs     = 17'(signed'(head.sample));
  assign habs   = hs[16] ? 17'(-hs) : 17'(hs);
  assign asum   = sum_r[31] ? 32'(-sum_r) : 32'(sum_r);

  always_comb begin
    we    = (st_r == S_CLEAR) || (st_r == S_ACC);
    waddr = (st_r == S_CLEAR) ? clr_r : addr_r;
    if (st_r == S_CLEAR) begin
      wdata = '0;
    end else begin
      wdata = {rd_sum + 32'(samp_r), rd_sq + 48'(sq_r)};
    end
    // restoring divide step, one quotient bit per cycle
    drem2 = {drem_r[ctms_pkg::REM_W-2:0], dq_r[ctms_pkg::DIV_W-1]};
    if (drem2 >= ctms_pkg::REM_W'(n_r)) begin
      drem_nxt = drem2 - ctms_pkg::REM_W'(n_r);
      dq_nxt   = {dq_r[ctms_pkg::DIV_W-2:0], 1'b1};
    end else begin
      drem_nxt = drem2;
      dq_nxt   = {dq_r[ctms_pkg::DIV_W-2:0], 1'b0};
    end
    srem2 = {srem_r[39:0], rad_r[79:78]};
    trial = {root_r, 2'b01};
    mmag  = 41'(dq_r) + 41'(drem_r != '0);
  end

  ctms_ram #(.WIDTH(MW), .DEPTH(ctms_pkg::STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
      it_r  <= '0;
      for (int i = 0; i < ctms_pkg::NUM_CLASSES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (pop && ov_r) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == ctms_pkg::STORE_DEPTH - 1) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            addr_r <= head.addr;
            cls_r  <= head.cls;
            n_r    <= hcnt;
            samp_r <= 32'(hs);
            sq_r   <= 34'(habs * habs);
            ce_r   <= head.clip_end;
            mean_r <= '0;
            root_r <= '0;
            case (head.op)
              ctms_pkg::OP_ACC: begin
                // saturated class drops both sample and clip end
                if (hcnt != '1) begin
                  st_r <= S_ACC;
                end
              end
              ctms_pkg::OP_READ: begin
                if (32'(hcnt) < ctms_pkg::MIN_CLIPS || !head.elem_ok) begin
                  st_r <= S_DONE;
                end else begin
                  st_r <= S_MUL1;
                end
              end
              default: begin
                n_r  <= '0;
                st_r <= S_DONE;
              end
            endcase
          end
        end
        S_ACC: begin
          if (ce_r) begin
            cnt_r[cls_r] <= cnt_r[cls_r] + 1'b1;
          end
          st_r <= S_IDLE;
        end
        S_MUL1: begin
          sum_r <= signed'(rd_sum);
          sqs_r <= rd_sq;
          plo_r <= 64'(n_r * rd_sq[23:0]);
          st_r  <= S_MUL2;
        end
        S_MUL2: begin
          phi_r <= 64'(n_r * sqs_r[47:24]);
          rhs_r <= 64'(asum * asum);
          neg_r <= sum_r[31];
          dq_r  <= {8'(asum >> 24), asum[23:0], 8'd0};
          st_r  <= S_LHS;
        end
        S_LHS: begin
          lhs_r <= plo_r + (phi_r << 24);
          st_r  <= S_SUB;
        end
        S_SUB: begin
          vz_r   <= (lhs_r <= rhs_r);
          rad_r  <= {lhs_r - rhs_r, 16'd0};
          drem_r <= '0;
          it_r   <= '0;
          st_r   <= S_DIVM;
        end
        S_DIVM: begin
          dq_r   <= dq_nxt;
          drem_r <= drem_nxt;
          it_r   <= it_r + 1'b1;
          if (32'(it_r) == ctms_pkg::DIV_W - 1) begin
            st_r <= S_MFIN;
          end
        end
        S_MFIN: begin
          // floor toward minus infinity, then clamp to 24 bits
          if (neg_r) begin
            mean_r <= (mmag > 41'd8388608) ? 24'h800000 : 24'(-mmag);
          end else begin
            mean_r <= (dq_r > 40'd8388607) ? 24'h7FFFFF : dq_r[23:0];
          end
          srem_r <= '0;
          root_r <= '0;
          it_r   <= '0;
          st_r   <= vz_r ? S_DONE : S_SQRT;
        end
        S_SQRT: begin
          rad_r <= rad_r << 2;
          if (srem2 >= trial) begin
            srem_r <= srem2 - trial;
            root_r <= {root_r[ctms_pkg::RT_W-2:0], 1'b1};
          end else begin
            srem_r <= srem2;
            root_r <= {root_r[ctms_pkg::RT_W-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (32'(it_r) == ctms_pkg::RT_W - 1) begin
            st_r <= S_SFIN;
          end
        end
        S_SFIN: begin
          dq_r   <= root_r;
          drem_r <= '0;
          it_r   <= '0;
          st_r   <= S_DIVS;
        end
        S_DIVS: begin
          dq_r   <= dq_nxt;
          drem_r <= drem_nxt;
          it_r   <= it_r + 1'b1;
          if (32'(it_r) == ctms_pkg::DIV_W - 1) begin
            root_r <= (dq_nxt > 40'hFFFFFF) ? 40'hFFFFFF : dq_nxt;
            st_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov_r) begin
            ov_r             <= 1'b1;
            out_mean_value   <= signed'(mean_r);
            out_stdev_value  <= root_r[23:0];
            out_clip_count   <= n_r;
            out_enough_clips <= (32'(n_r) >= ctms_pkg::MIN_CLIPS);
            st_r             <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> !bk_stat.clearing) else $error("queue popped during clear");
  a_acc_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ACC) |-> $past(st_r) == S_IDLE) else $error("store write out of order");
  a_it_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(it_r) <= ctms_pkg::DIV_W) else $error("iteration count overrun");
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && !ov_r) |=> ov_r) else $error("result lost");

endmodule

@@ rtl/clip_template_mean_stdev.sv @@
// Top level of the clip template mean/stdev accumulator.
// Accumulate: each transfer runs the idle and store-write states; a read with
// enough clips runs a 40-step serial divide, then a 40-step square root and a
// 40-step divide unless the variance is zero. A 4-entry queue decouples input
// from engine; one output register holds a result. Synchronous active-low reset;
// then a clearing pass zeroes all 8192 store entries while full stays high.
module clip_template_mean_stdev (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_action,
  input  logic [4:0]         in_label,
  input  logic [8:0]         in_element_index,
  input  logic signed [15:0] in_sample,
  input  logic               in_clip_end,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] out_mean_value,
  output logic [23:0]        out_stdev_value,
  output logic [15:0]        out_clip_count,
  output logic               out_enough_clips
);

  ctms_pkg::ctms_entry_t   head;
  ctms_pkg::ctms_bk_stat_t bk_stat;
  logic                    q_empty;

  ctms_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_label         (in_label),
    .in_element_index (in_element_index),
    .in_sample        (in_sample),
    .in_clip_end      (in_clip_end),
    .bk_stat          (bk_stat),
    .head             (head),
    .q_empty          (q_empty)
  );

  ctms_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .bk_stat          (bk_stat),
    .empty            (empty),
    .pop              (pop),
    .out_mean_value   (out_mean_value),
    .out_stdev_value  (out_stdev_value),
    .out_clip_count   (out_clip_count),
    .out_enough_clips (out_enough_clips)
  );

endmodule

@@ test/tb_top.sv @@
// Testbench for clip_template_mean_stdev: predicts per-class mean/stdev reads.
`timescale 1ns / 100ps

module tb_top;

  localparam logic ACT_ACC  = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam int   WDOG_LIMIT = 40000;
  localparam int   TAIL_ITEMS = 150;

  typedef struct {
    logic               action;
    logic [4:0]         label;
    logic [8:0]         elem;
    logic signed [15:0] sample;
    logic               clip_end;
    bit                 drain;    // hold until all reads have returned
  } clip_item_t;

  typedef struct {
    logic signed [23:0] mean;
    logic [23:0]        stdev;
    logic [15:0]        count;
    logic               enough;
  } template_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               in_action = 1'b0;
  logic [4:0]         in_label = '0;
  logic [8:0]         in_element_index = '0;
  logic signed [15:0] in_sample = '0;
  logic               in_clip_end = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [23:0] out_mean_value;
  logic [23:0]        out_stdev_value;
  logic [15:0]        out_clip_count;
  logic               out_enough_clips;

  clip_item_t pending_items[$];
  template_t  expected_templates[$];

  logic signed [31:0] sum_tab [ctms_pkg::STORE_DEPTH];
  logic [47:0]        sqsum_tab [ctms_pkg::STORE_DEPTH];
  logic [15:0]        clip_cnt [ctms_pkg::NUM_CLASSES];

  int  errors = 0;
  int  send_idle = 0;
  int  recv_idle = 0;
  int  quiet_cycles = 0;

  always #10 clk = ~clk;

  clip_template_mean_stdev dut (.*);

  // floor(sqrt(v * 2^16)), restoring method over 80 bits
  function automatic logic [39:0] root_q16(input logic [63:0] v);
    logic [79:0] x;
    logic [81:0] rem;
    logic [81:0] trial;
    logic [39:0] root;
    x = {v, 16'h0};
    rem = '0;
    root = '0;
    for (int i = 39; i >= 0; i--) begin
      rem = (rem << 2) | ((x >> (2 * i)) & 80'd3);
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[38:0], 1'b1};
      end else begin
        root = {root[38:0], 1'b0};
      end
    end
    return root;
  endfunction

  task automatic apply_item(input logic action, input logic [4:0] label,
                            input logic [8:0] elem, input logic signed [15:0] sample,
                            input logic clip_end);
    int cls;
    int idx;
    longint s;
    longint n;
    longint a;
    longint q;
    logic [63:0] asum;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] sd;
    template_t t;
    if (action == ACT_ACC) begin
      if (label < 1 || label > ctms_pkg::NUM_CLASSES || elem >= ctms_pkg::ELEMS) return;
      cls = label - 1;
      if (clip_cnt[cls] == 16'hFFFF) return;
      idx = cls * ctms_pkg::ELEMS + elem;
      s = sample;
      sum_tab[idx] = sum_tab[idx] + 32'(s);
      sqsum_tab[idx] = sqsum_tab[idx] + 48'(s * s);
      if (clip_end) clip_cnt[cls] = clip_cnt[cls] + 16'd1;
      return;
    end
    t = '{mean: '0, stdev: '0, count: '0, enough: 1'b0};
    if (label >= 1 && label <= ctms_pkg::NUM_CLASSES) begin
      cls = label - 1;
      n = clip_cnt[cls];
      t.count = clip_cnt[cls];
      t.enough = (n >= ctms_pkg::MIN_CLIPS);
      if (n >= ctms_pkg::MIN_CLIPS && elem < ctms_pkg::ELEMS) begin
        idx = cls * ctms_pkg::ELEMS + elem;
        a = longint'(sum_tab[idx]) * 256;
        q = a / n;
        if ((a % n) != 0 && a < 0) q--;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        t.mean = 24'(q);
        asum = (sum_tab[idx] < 0) ? 64'(-longint'(sum_tab[idx])) : 64'(sum_tab[idx]);
        lhs = 64'(n) * 64'(sqsum_tab[idx]);
        rhs = asum * asum;
        if (lhs > rhs) begin
          sd = 64'(root_q16(lhs - rhs)) / 64'(n);
          t.stdev = (sd > 64'hFFFFFF) ? 24'hFFFFFF : 24'(sd);
        end
      end
    end
    expected_templates.push_back(t);
  endtask

  // sender
  always @(posedge clk) begin
    clip_item_t it;
    bit tail;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      tail = pending_items.size() < TAIL_ITEMS;
      if (push && !full)
        apply_item(in_action, in_label, in_element_index, in_sample, in_clip_end);
      if (!push || !full) begin
        if (send_idle > 0) begin
          send_idle--;
          push <= 1'b0;
        end else if (pending_items.size() == 0) begin
          push <= 1'b0;
        end else if (pending_items[0].drain && expected_templates.size() != 0) begin
          push <= 1'b0;
        end else if (!tail && $urandom_range(0, 15) == 0) begin
          send_idle = $urandom_range(1, 18) - 1;
          push <= 1'b0;
        end else begin
          it = pending_items.pop_front();
          in_action <= it.action;
          in_label <= it.label;
          in_element_index <= it.elem;
          in_sample <= it.sample;
          in_clip_end <= it.clip_end;
          push <= 1'b1;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    template_t t;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_templates.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          t = expected_templates.pop_front();
          if (out_mean_value !== t.mean) begin
            $error("mean_value: expected %0d, got %0d", t.mean, out_mean_value);
            errors++;
          end
          if (out_stdev_value !== t.stdev) begin
            $error("stdev_value: expected %0d, got %0d", t.stdev, out_stdev_value);
            errors++;
          end
          if (out_clip_count !== t.count) begin
            $error("clip_count: expected %0d, got %0d", t.count, out_clip_count);
            errors++;
          end
          if (out_enough_clips !== t.enough) begin
            $error("enough_clips: expected %0d, got %0d", t.enough, out_enough_clips);
            errors++;
          end
        end
      end
      if (recv_idle > 0) begin
        recv_idle--;
        pop <= 1'b0;
      end else if (pending_items.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
        recv_idle = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic clip_item_t mk(input logic action, input logic [4:0] label,
                                    input logic [8:0] elem, input logic [15:0] sample,
                                    input logic clip_end);
    clip_item_t it;
    it = '{action: action, label: label, elem: elem, sample: sample,
           clip_end: clip_end, drain: 1'b0};
    return it;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clip_item_t it;
    int r;
    for (int i = 0; i < ctms_pkg::STORE_DEPTH; i++) begin
      sum_tab[i] = '0;
      sqsum_tab[i] = '0;
    end
    for (int i = 0; i < ctms_pkg::NUM_CLASSES; i++) clip_cnt[i] = '0;

    // reads of an empty class, then growth through one and two clips
    pending_items.push_back(mk(ACT_READ, 5'd1, 9'd0, 16'h0, 1'b0));
    pending_items.push_back(mk(ACT_ACC, 5'd1, 9'd0, 16'h8000, 1'b0));
    pending_items.push_back(mk(ACT_ACC, 5'd1, 9'd0, 16'h7FFF, 1'b1));
    pending_items.push_back(mk(ACT_READ, 5'd1, 9'd0, 16'h0, 1'b0));
    pending_items.push_back(mk(ACT_ACC, 5'd1, 9'd511, 16'hFFFF, 1'b1));
    pending_items.push_back(mk(ACT_ACC, 5'd1, 9'd0, 16'h8000, 1'b0));
    pending_items.push_back(mk(ACT_READ, 5'd1, 9'd0, 16'hFFFF, 1'b1));
    pending_items.push_back(mk(ACT_READ, 5'd1, 9'd511, 16'h0, 1'b0));
    pending_items.push_back(mk(ACT_READ, 5'd1, 9'd77, 16'h0, 1'b0));
    // unlabeled and unknown classes
    pending_items.push_back(mk(ACT_ACC, 5'd0, 9'd1, 16'h1234, 1'b1));
    pending_items.push_back(mk(ACT_ACC, 5'd17, 9'd1, 16'h1234, 1'b1));
    pending_items.push_back(mk(ACT_ACC, 5'd31, 9'd1, 16'h1234, 1'b1));
    pending_items.push_back(mk(ACT_READ, 5'd0, 9'd1, 16'h0, 1'b0));
    pending_items.push_back(mk(ACT_READ, 5'd17, 9'd1, 16'h0, 1'b0));
    pending_items.push_back(mk(ACT_READ, 5'd31, 9'h1FF, 16'h0, 1'b0));

    for (int i = 0; i < 1290; i++) begin
      r = $urandom_range(0, 99);
      it.action = (r < 15) ? ACT_READ : ACT_ACC;
      if ($urandom_range(0, 9) == 0) it.label = ($urandom_range(0, 1) != 0) ? 5'd0
                                              : 5'($urandom_range(17, 31));
      else it.label = 5'($urandom_range(1, 16));
      if ($urandom_range(0, 1) != 0) it.elem = 9'($urandom_range(0, 511));
      else it.elem = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 3))
                                                 : 9'($urandom_range(508, 511));
      it.sample = rand_sample();
      it.clip_end = ($urandom_range(0, 9) == 0);
      it.drain = (i == 650);
      pending_items.push_back(it);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0);
    @(posedge clk);
    while (push || expected_templates.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ clip_template_mean_stdev.f @@
rtl/ctms_pkg.sv
rtl/ctms_ram.sv
rtl/ctms_front.sv
rtl/ctms_back.sv
rtl/clip_template_mean_stdev.sv
test/tb_top.sv
